FILE: sv/bmh_pkg.sv
// Shared types and codes for the binary max-heap core.
`default_nettype none

package bmh_pkg;

  localparam int unsigned KEY_MAX = 32;  // key bits carried between cells
  localparam int unsigned IDX_W   = 17;  // widest heap slot index supported
  localparam int unsigned DEP_W   = 5;   // tree level number

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_FETCH_WAIT,
    S_RUN,
    S_FINISH
  } state_t;

  // Sift token handed from one level to the next. node is the parent slot
  // whose children the receiving level holds.
  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic [KEY_MAX-1:0]   val;
    logic [IDX_W-1:0]     node;
    logic [IDX_W-1:0]     cnt;
    logic [IDX_W-1:0]     path;
    logic [DEP_W-1:0]     depth;
  } tok_t;

  // Final value for the parent slot, sent one level up.
  typedef struct packed {
    logic               valid;
    logic [KEY_MAX-1:0] val;
  } wb_t;

  // Random read of one slot, used to fetch the last key on delete.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } fetch_t;

endpackage

`default_nettype wire

FILE: sv/bmh_cell.sv
// One tree level of the heap: pair storage and the per-level sift step.
`default_nettype none

module bmh_cell #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned KW       = 32,
  parameter int unsigned LEVEL    = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bmh_pkg::tok_t                 tok_in,
  output bmh_pkg::tok_t                 tok_out,
  input  bmh_pkg::wb_t                  wb_in,
  output bmh_pkg::wb_t                  wb_out,
  input  bmh_pkg::fetch_t               fetch_req,
  output logic [bmh_pkg::KEY_MAX-1:0]   fetch_data,
  output logic                          done
);
  import bmh_pkg::*;

  localparam int unsigned FIRST     = 1 << LEVEL;
  localparam int unsigned HALF_FULL = 1 << (LEVEL - 1);
  localparam int unsigned PAIRS     = (CAPACITY >= 2 * FIRST - 1) ? HALF_FULL
                                      : ((CAPACITY - FIRST) >> 1) + 1;
  localparam int unsigned AW        = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam bit          LAST      = (2 * FIRST > CAPACITY);

  // word {right, left} of the two children of one parent
  logic [2*KW-1:0] mem [PAIRS];
  logic [2*KW-1:0] rdata;

  tok_t            tok_q;
  logic            pend;
  logic            fhit;
  logic            fsel;
  logic [AW-1:0]   hold_addr;
  logic [2*KW-1:0] hold_pair;
  logic            hold_sel;

  logic            fetch_hit_now;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   waddr;
  logic [KW-1:0]   left;
  logic [KW-1:0]   right;
  logic [KW-1:0]   v;
  logic [KW-1:0]   s;
  logic [KW-1:0]   m;
  logic [KW-1:0]   keep;
  logic [KW-1:0]   carry;
  logic [KW-1:0]   wb_val;
  logic [IDX_W:0]  lf;
  logic [IDX_W:0]  rf;
  logic [IDX_W:0]  cntx;
  logic            sel;
  logic            cont;
  logic            we;
  logic            pick_r;
  logic            at_tgt;
  logic [2*KW-1:0] wd;
  logic [KW-1:0]   wb_key;
  tok_t            tok_next;

  function automatic logic [AW-1:0] pair_addr(input logic [IDX_W-1:0] parent);
    logic [IDX_W-1:0] tmp;
    tmp = parent & IDX_W'(HALF_FULL - 1);
    return tmp[AW-1:0];
  endfunction

  assign fetch_hit_now = fetch_req.valid && ((fetch_req.idx >> LEVEL) == IDX_W'(1));
  assign rd_en   = tok_in.valid || fetch_hit_now;
  assign rd_addr = tok_in.valid ? pair_addr(tok_in.node) : pair_addr(fetch_req.idx >> 1);
  assign waddr   = pair_addr(tok_q.node);

  assign left  = rdata[KW-1:0];
  assign right = rdata[2*KW-1:KW];
  assign v     = tok_q.val[KW-1:0];
  assign lf    = {1'b0, tok_q.node} << 1;
  assign rf    = lf | (IDX_W + 1)'(1);
  assign cntx  = {1'b0, tok_q.cnt};

  always_comb begin
    sel    = 1'b0;
    cont   = 1'b0;
    we     = 1'b0;
    keep   = v;
    carry  = v;
    wb_val = v;
    s      = left;
    m      = left;
    pick_r = 1'b0;
    at_tgt = 1'b0;
    if (tok_q.op == OP_INSERT) begin
      // top-down insert: larger key stays, smaller moves on toward the new slot
      sel    = tok_q.path[IDX_W-1-LEVEL];
      s      = sel ? right : left;
      at_tgt = (tok_q.depth == DEP_W'(LEVEL));
      we     = 1'b1;
      if (at_tgt) begin
        keep = v;
      end else begin
        keep  = (v > s) ? v : s;
        carry = (v > s) ? s : v;
        cont  = 1'b1;
      end
    end else begin
      pick_r = (rf <= cntx) && (left < right);
      m      = pick_r ? right : left;
      sel    = pick_r;
      if ((lf <= cntx) && (v < m)) begin
        // child moves up, carried key sits in its slot until the next level decides
        wb_val = m;
        we     = 1'b1;
        cont   = 1'b1;
      end
    end
    wd = sel ? {keep, left} : {right, keep};
  end

  always_comb begin
    tok_next       = tok_q;
    tok_next.valid = pend && cont && !LAST;
    tok_next.val   = KEY_MAX'(carry);
    tok_next.node  = (tok_q.node << 1) | IDX_W'(sel);
  end

  assign done        = pend && (!cont || LAST);
  assign wb_out.valid = pend && (tok_q.op == OP_DELETE);
  assign wb_out.val   = KEY_MAX'(wb_val);
  assign fetch_data   = fhit ? KEY_MAX'(fsel ? right : left) : '0;
  assign wb_key       = wb_in.val[KW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      fhit <= 1'b0;
    end else begin
      pend <= tok_in.valid;
      fhit <= fetch_hit_now && !tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      tok_q <= tok_in;
    end
    fsel <= fetch_req.idx[0];
    if (pend) begin
      hold_addr <= waddr;
      hold_pair <= wd;
      hold_sel  <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (pend && we) begin
      mem[waddr] <= wd;
    end else if (wb_in.valid) begin
      mem[hold_addr] <= hold_sel ? {wb_key, hold_pair[KW-1:0]}
                                 : {hold_pair[2*KW-1:KW], wb_key};
    end
  end

endmodule

`default_nettype wire

FILE: sv/binary_max_heap_core.sv
// Binary max-heap priority queue: root and control with a row of level cells.
//
// Input channel (in_valid/in_ready, op, key): op insert pushes key, op delete
// pops the maximum. One word is in flight at a time; in_ready is high only
// while the controller is idle. Output channel (out_valid/out_ready) returns
// one word per input: top_value, entries, is_empty and status.
// Each tree level below the root is one cell holding that level's keys as
// child pairs. A sift token walks the cells; at each level the cell first
// reads the pair, then compares and writes. Full inserts, empty deletes
// and trivial cases skip the sift and finish directly.
// The result sits in an output register; a new word is accepted while it
// waits, but the next result holds until out_ready takes the old one.
// Reset clears the count and the channel state; key storage is not cleared
// and is read only at slots that hold keys.
`default_nettype none

module binary_max_heap_core #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic [31:0]                           key,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [31:0]                           top_value,
  output logic [$clog2(CAPACITY+1)-1:0]         entries,
  output logic                                  is_empty,
  output bmh_pkg::status_t                      status
);
  import bmh_pkg::*;

  localparam int unsigned KW     = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [KW-1:0]   root;
  logic [KW-1:0]   root_next;
  status_t         status_q;
  status_t         status_next;
  tok_t            tok0;
  tok_t            tok_next;
  fetch_t          freq;
  fetch_t          freq_next;

  logic            accept;
  logic            load_out;
  logic [KW-1:0]   key_in;
  logic [CW-1:0]   slot;
  logic [IDX_W-1:0] slot_x;
  logic [DEP_W-1:0] slot_d;
  logic [KEY_MAX-1:0] fetch_or;

  tok_t               tok   [1:LEVELS];
  wb_t                wb    [1:LEVELS];
  logic [KEY_MAX-1:0] fdata [1:LEVELS-1];
  logic [LEVELS-1:1]  done_vec;

  function automatic logic [DEP_W-1:0] msb_pos(input logic [IDX_W-1:0] x);
    logic [DEP_W-1:0] r;
    r = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (x[i]) r = DEP_W'(i);
    end
    return r;
  endfunction

  assign key_in = key[KW-1:0];
  assign slot   = count + CW'(1);
  assign slot_x = IDX_W'(slot);
  assign slot_d = msb_pos(slot_x);

  assign tok[1]      = tok0;
  assign wb[LEVELS]  = '0;

  for (genvar g = 1; g < LEVELS; g++) begin : g_level
    bmh_cell #(
      .CAPACITY (CAPACITY),
      .KW       (KW),
      .LEVEL    (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[g]),
      .tok_out    (tok[g+1]),
      .wb_in      (wb[g+1]),
      .wb_out     (wb[g]),
      .fetch_req  (freq),
      .fetch_data (fdata[g]),
      .done       (done_vec[g])
    );
  end

  always_comb begin
    fetch_or = '0;
    for (int i = 1; i < LEVELS; i++) begin
      fetch_or = fetch_or | fdata[i];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op == OP_INSERT) begin
            state_next = ((count == CAP_C) || (count == '0)) ? S_FINISH : S_RUN;
          end else begin
            state_next = (count <= CW'(1)) ? S_FINISH : S_FETCH;
          end
        end
      end
      S_FETCH:      state_next = S_FETCH_WAIT;
      S_FETCH_WAIT: state_next = S_RUN;
      S_RUN: begin
        if (|done_vec) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs and datapath updates
  always_comb begin
    in_ready    = (state == S_IDLE);
    accept      = in_valid && in_ready;
    load_out    = (state == S_FINISH) && (!out_valid || out_ready);
    count_next  = count;
    root_next   = root;
    status_next = status_q;
    freq_next.valid = 1'b0;
    freq_next.idx   = IDX_W'(count);
    tok_next.valid = 1'b0;
    tok_next.op    = OP_INSERT;
    tok_next.val   = '0;
    tok_next.node  = IDX_W'(1);
    tok_next.cnt   = IDX_W'(count);
    tok_next.path  = slot_x << (DEP_W'(IDX_W - 1) - slot_d);
    tok_next.depth = slot_d;
    if (accept) begin
      status_next = ST_DONE;
      if (op == OP_INSERT) begin
        if (count == CAP_C) begin
          status_next = ST_FULL;
        end else if (count == '0) begin
          root_next  = key_in;
          count_next = CW'(1);
        end else begin
          root_next      = (key_in > root) ? key_in : root;
          tok_next.valid = 1'b1;
          tok_next.val   = KEY_MAX'((key_in > root) ? root : key_in);
          count_next     = slot;
        end
      end else begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          count_next      = count - CW'(1);
          freq_next.valid = (count != CW'(1));
        end
      end
    end
    if (state == S_FETCH_WAIT) begin
      // last key is back; sift it down from the root with the new count
      tok_next.valid = 1'b1;
      tok_next.op    = OP_DELETE;
      tok_next.val   = fetch_or;
      tok_next.node  = IDX_W'(1);
      tok_next.cnt   = IDX_W'(count);
    end
    if (wb[1].valid) begin
      root_next = wb[1].val[KW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok0 <= '0;
      freq <= '0;
    end else begin
      tok0 <= tok_next;
      freq <= freq_next;
    end
  end

  always_ff @(posedge clk) begin
    root     <= root_next;
    status_q <= status_next;
    if (load_out) begin
      top_value <= (count != '0) ? 32'(root) : '0;
      entries   <= count;
      is_empty  <= (count == '0);
      status    <= status_q;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("entry count above capacity");

  a_done_one: assert property (@(posedge clk) disable iff (rst) $onehot0(done_vec))
    else $error("more than one level finished a sift");

  a_done_run: assert property (@(posedge clk) disable iff (rst)
    (|done_vec) |-> (state == S_RUN))
    else $error("sift finished outside run state");

  a_tail_quiet: assert property (@(posedge clk) disable iff (rst) !tok[LEVELS].valid)
    else $error("token left the deepest level");

  a_root_wb: assert property (@(posedge clk) disable iff (rst)
    wb[1].valid |-> (state == S_RUN))
    else $error("root write-back outside run state");

endmodule

`default_nettype wire
